[hdl/triad_pkg.sv]
// Package with item types, controller commands and the update step of the TRIAD-SC cipher.
package triad_pkg;

  localparam int LEN_A = 80;
  localparam int LEN_B = 88;
  localparam int LEN_C = 88;
  localparam int MAX_ROUNDS = 8;
  localparam int DATA_ROUNDS = 8;

  localparam logic [1:0] CFG_KEY_HIGH   = 2'd0;
  localparam logic [1:0] CFG_KEY_LOW    = 2'd1;
  localparam logic [1:0] CFG_NONCE_HIGH = 2'd2;
  localparam logic [1:0] CFG_NONCE_LOW  = 2'd3;

  localparam logic ACT_INIT = 1'b0;
  localparam logic ACT_DATA = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       was_init;
  } out_item_t;

  typedef struct packed {
    logic                  capture;
    logic                  load;
    logic                  clear_ks;
    logic [MAX_ROUNDS-1:0] round_en;
    logic                  out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [LEN_A-1:0] a;
    logic [LEN_B-1:0] b;
    logic [LEN_C-1:0] c;
  } triad_state_t;

  // Bit p of a register (1 = head) sits at index width - p.
  function automatic logic keystream_bit(triad_state_t s);
    logic t1, t2, t3;
    t1 = s.a[12] ^ s.a[0] ^ (s.b[3] & s.c[3]);
    t2 = s.b[24] ^ s.b[0];
    t3 = s.c[20] ^ s.c[0];
    return t1 ^ t2 ^ t3;
  endfunction

  function automatic triad_state_t update_state(triad_state_t s);
    logic t1, t2, t3, fa, fb, fc;
    triad_state_t r;
    t1 = s.a[12] ^ s.a[0] ^ (s.b[3] & s.c[3]);
    t2 = s.b[24] ^ s.b[0];
    t3 = s.c[20] ^ s.c[0];
    fb = t1 ^ (s.a[7] & s.a[1]) ^ s.b[22];
    fc = t2 ^ (s.b[23] & s.b[1]) ^ s.c[4];
    fa = t3 ^ (s.c[11] & s.c[1]) ^ s.a[6];
    r.a = {fa, s.a[LEN_A-1:1]};
    r.b = {fb, s.b[LEN_B-1:1]};
    r.c = {fc, s.c[LEN_C-1:1]};
    return r;
  endfunction

endpackage

[hdl/triad_sc_keystream_cipher_top.sv]
// Top level of the TRIAD-SC keystream cipher.
// The configuration channel writes key_high, key_low, nonce_high and nonce_low by
// index when cfg_valid is high; cfg_ready is always high.
// An input item with action 0 loads the three shift registers from key, nonce and
// constant bytes and runs INIT_ROUNDS updates; its result has was_init set and a
// zero byte. An item with action 1 runs eight updates and returns the data byte
// XORed with the keystream byte, least significant bit first.
// The block works on one item at a time. An item is accepted in the idle state,
// then stays in the update chain state until all of its rounds are done, then
// the write state writes the result register once the output register is free.
// in_stall is high from acceptance until the result is written. A result waits
// in the output register while out_stall is high; a finished item waits for the
// register to free before the next item is accepted.
// Reset clears the configuration and shift registers to zero and empties the
// output register.
module triad_sc_keystream_cipher_top
  import triad_pkg::*;
#(
  parameter int INIT_ROUNDS = 1024,
  parameter int ROUNDS_PER_CYCLE = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item
);

  dp_cmd_t cmd;

  assign cfg_ready = 1'b1;

  triad_ctrl #(
    .INIT_ROUNDS      (INIT_ROUNDS),
    .ROUNDS_PER_CYCLE (ROUNDS_PER_CYCLE)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_action (in_item.action),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  triad_datapath #(
    .ROUNDS_PER_CYCLE (ROUNDS_PER_CYCLE)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .out_item  (out_item)
  );

endmodule

[hdl/triad_ctrl.sv]
// Controller state machine that sequences initialization and data items.
module triad_ctrl
  import triad_pkg::*;
#(
  parameter int INIT_ROUNDS = 1024,
  parameter int ROUNDS_PER_CYCLE = 8
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  logic    in_action,
  output logic    out_valid,
  input  logic    out_stall,
  output dp_cmd_t cmd
);

  localparam int MAX_COUNT = (INIT_ROUNDS > DATA_ROUNDS) ? INIT_ROUNDS : DATA_ROUNDS;
  localparam int CW_RAW = $clog2(MAX_COUNT + 1);
  localparam int CW = (CW_RAW < 4) ? 4 : CW_RAW;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;

  logic [1:0]    state, state_next;
  logic [CW-1:0] remaining, remaining_next;
  logic          out_valid_next;
  logic          accept;
  logic          out_free;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next     = state;
    remaining_next = remaining;
    cmd            = '0;
    out_valid_next = out_valid && out_stall;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          if (in_action == ACT_INIT) begin
            cmd.load       = 1'b1;
            remaining_next = CW'(INIT_ROUNDS);
          end else begin
            cmd.clear_ks   = 1'b1;
            remaining_next = CW'(DATA_ROUNDS);
          end
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        for (int j = 0; j < MAX_ROUNDS; j++) begin
          cmd.round_en[j] = (j < ROUNDS_PER_CYCLE) && (remaining > CW'(j));
        end
        if (remaining > CW'(ROUNDS_PER_CYCLE)) begin
          remaining_next = remaining - CW'(ROUNDS_PER_CYCLE);
        end else begin
          remaining_next = '0;
          state_next     = S_WRITE;
        end
      end
      S_WRITE: begin
        if (out_free) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      remaining <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      remaining <= remaining_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

[hdl/triad_datapath.sv]
// Datapath with the configuration registers, the three shift registers and the result register.
module triad_datapath
  import triad_pkg::*;
#(
  parameter int ROUNDS_PER_CYCLE = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  in_item_t    in_item,
  input  dp_cmd_t     cmd,
  output out_item_t   out_item
);

  logic [63:0]  key_high, key_low, nonce_low;
  logic [31:0]  nonce_high;
  triad_state_t st, st_next, st_load;
  logic [7:0]   ks, ks_next;
  logic         action;
  logic [7:0]   data_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high   <= '0;
      key_low    <= '0;
      nonce_high <= '0;
      nonce_low  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_KEY_HIGH:   key_high   <= cfg_data;
        CFG_KEY_LOW:    key_low    <= cfg_data;
        CFG_NONCE_HIGH: nonce_high <= cfg_data[31:0];
        CFG_NONCE_LOW:  nonce_low  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Registers read head first as byte strings of key, nonce and constant bytes.
  assign st_load.a = {nonce_high[31:24], key_high[31:24], 8'hFF, key_high[39:32], 8'hFF,
                      key_high[47:40], 8'hFF, key_high[55:48], 8'hFE, key_high[63:56]};
  assign st_load.b = {nonce_low[7:0], nonce_low[15:8], nonce_low[23:16], nonce_low[31:24],
                      nonce_low[39:32], nonce_low[47:40], nonce_low[55:48], nonce_low[63:56],
                      nonce_high[7:0], nonce_high[15:8], nonce_high[23:16]};
  assign st_load.c = {key_low[7:0], key_low[15:8], key_low[23:16], key_low[31:24],
                      key_low[39:32], key_low[47:40], key_low[55:48], key_low[63:56],
                      key_high[7:0], key_high[15:8], key_high[23:16]};

  always_comb begin
    triad_state_t s;
    logic [7:0]   k;
    s = st;
    k = ks;
    for (int j = 0; j < ROUNDS_PER_CYCLE; j++) begin
      if (cmd.round_en[j]) begin
        k = {keystream_bit(s), k[7:1]};
        s = update_state(s);
      end
    end
    st_next = s;
    ks_next = k;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (cmd.load) begin
      st <= st_load;
    end else begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_ks) begin
      ks <= '0;
    end else begin
      ks <= ks_next;
    end
    if (cmd.capture) begin
      action    <= in_item.action;
      data_byte <= in_item.data_byte;
    end
    if (cmd.out_load) begin
      out_item.was_init <= (action == ACT_INIT);
      out_item.out_byte <= (action == ACT_INIT) ? 8'h00 : (data_byte ^ ks);
    end
  end

endmodule

[bench/tb.sv]
// Self-checking testbench for the TRIAD-SC keystream cipher top level.
`timescale 1ns / 1ps

module tb
  import triad_pkg::*;
();

  localparam int INIT_ROUNDS = 1024;
  localparam int LONG_HOLD = 300;
  localparam int PHASE_ITEMS = 72;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_KEY_HIGH;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;

  in_item_t    tx_items[$];
  out_item_t   due_outputs[$];

  logic [127:0]     mirror_key;
  logic [95:0]      mirror_nonce;
  logic [LEN_A-1:0] ks_a;
  logic [LEN_B-1:0] ks_b;
  logic [LEN_C-1:0] ks_c;

  logic calm = 1'b0;
  int   errors = 0;
  int   results_seen;
  int   n_init;
  int   n_data;
  int   n_settings = 0;
  int   tx_wait;
  int   rx_wait;
  int   rx_next;
  int   hold_left;
  int   hold_stage;
  out_item_t want;

  triad_sc_keystream_cipher_top #(
    .INIT_ROUNDS(INIT_ROUNDS),
    .ROUNDS_PER_CYCLE(8)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item)
  );

  always #5 clk = ~clk;

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  function automatic logic ks_update();
    logic t1, t2, t3, fa, fb, fc;
    t1 = ks_a[LEN_A-68] ^ ks_a[LEN_A-80] ^ (ks_b[LEN_B-85] & ks_c[LEN_C-85]);
    t2 = ks_b[LEN_B-64] ^ ks_b[LEN_B-88];
    t3 = ks_c[LEN_C-68] ^ ks_c[LEN_C-88];
    fb = t1 ^ (ks_a[LEN_A-73] & ks_a[LEN_A-79]) ^ ks_b[LEN_B-66];
    fc = t2 ^ (ks_b[LEN_B-65] & ks_b[LEN_B-87]) ^ ks_c[LEN_C-84];
    fa = t3 ^ (ks_c[LEN_C-77] & ks_c[LEN_C-87]) ^ ks_a[LEN_A-74];
    ks_a = {fa, ks_a[LEN_A-1:1]};
    ks_b = {fb, ks_b[LEN_B-1:1]};
    ks_c = {fc, ks_c[LEN_C-1:1]};
    return t1 ^ t2 ^ t3;
  endfunction

  function automatic out_item_t cipher_step(in_item_t it);
    out_item_t  r;
    logic [7:0] ks;
    if (it.action == ACT_INIT) begin
      ks_a = {mirror_nonce[95:88], mirror_key[95:88], 8'hFF, mirror_key[103:96],
              8'hFF, mirror_key[111:104], 8'hFF, mirror_key[119:112], 8'hFE,
              mirror_key[127:120]};
      for (int i = 0; i < 11; i++) begin
        ks_b[8*i +: 8] = mirror_nonce[95-8*(i+1) -: 8];
        ks_c[8*i +: 8] = mirror_key[127-8*(i+5) -: 8];
      end
      repeat (INIT_ROUNDS) void'(ks_update());
      r.out_byte = 8'h00;
      r.was_init = 1'b1;
    end else begin
      for (int i = 0; i < 8; i++) ks[i] = ks_update();
      r.out_byte = it.data_byte ^ ks;
      r.was_init = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tx_wait <= 0;
    end else if (!(in_valid && in_stall)) begin
      if (tx_wait > 0) begin
        tx_wait <= tx_wait - 1;
        in_valid <= 1'b0;
      end else if (tx_items.size() > 0) begin
        in_item <= tx_items.pop_front();
        in_valid <= 1'b1;
        tx_wait <= draw_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      rx_wait <= 0;
      hold_left <= 0;
      hold_stage <= 0;
    end else if (hold_stage < 2 && results_seen == ((hold_stage == 0) ? 60 : 400)) begin
      hold_stage <= hold_stage + 1;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= (hold_left > 1);
    end else if (out_valid && !out_stall) begin
      rx_next = draw_gap();
      rx_wait <= rx_next;
      out_stall <= (rx_next > 0);
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      out_stall <= (rx_wait > 1);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      mirror_key = '0;
      mirror_nonce = '0;
      ks_a = '0;
      ks_b = '0;
      ks_c = '0;
      results_seen <= 0;
      n_init <= 0;
      n_data <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (due_outputs.size() == 0) begin
          errors++;
          $display("%0t: expected no result, got out_byte %02h was_init %0b",
                   $time, out_item.out_byte, out_item.was_init);
        end else begin
          want = due_outputs.pop_front();
          if (out_item.out_byte !== want.out_byte) begin
            errors++;
            $display("%0t: out_byte expected %02h, got %02h",
                     $time, want.out_byte, out_item.out_byte);
          end
          if (out_item.was_init !== want.was_init) begin
            errors++;
            $display("%0t: was_init expected %0b, got %0b",
                     $time, want.was_init, out_item.was_init);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_KEY_HIGH:   mirror_key[127:64] = cfg_data;
          CFG_KEY_LOW:    mirror_key[63:0] = cfg_data;
          CFG_NONCE_HIGH: mirror_nonce[95:64] = cfg_data[31:0];
          CFG_NONCE_LOW:  mirror_nonce[63:0] = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        due_outputs.insert(due_outputs.size(), cipher_step(in_item));
        if (in_item.action == ACT_INIT) n_init <= n_init + 1;
        else n_data <= n_data + 1;
      end
    end
  end

  task automatic push_item(logic act, logic [7:0] value);
    in_item_t it;
    it.action = act;
    it.data_byte = value;
    tx_items.insert(tx_items.size(), it);
  endtask

  task automatic settle();
    do @(negedge clk);
    while (tx_items.size() != 0 || in_valid || due_outputs.size() != 0 || out_valid);
    repeat (4) @(negedge clk);
  endtask

  task automatic send_reg(logic [1:0] idx, logic [63:0] value);
    logic ok;
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do begin
      @(negedge clk);
      ok = cfg_ready;
    end while (!ok);
  endtask

  task automatic write_config(logic [63:0] kh, logic [63:0] kl, logic [63:0] nh,
                              logic [63:0] nl);
    send_reg(CFG_KEY_HIGH, kh);
    send_reg(CFG_KEY_LOW, kl);
    send_reg(CFG_NONCE_HIGH, nh);
    send_reg(CFG_NONCE_LOW, nl);
    @(posedge clk);
    cfg_valid <= 1'b0;
    n_settings++;
    @(negedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  initial begin
    int n;
    int pick;
    int len;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Before any init the zero state gives zero keystream and bytes pass through.
    push_item(ACT_DATA, 8'h00);
    push_item(ACT_DATA, 8'hFF);
    push_item(ACT_DATA, 8'h5A);
    push_item(ACT_INIT, 8'h00);
    push_item(ACT_DATA, 8'h00);
    push_item(ACT_DATA, 8'hFF);
    push_item(ACT_DATA, 8'h80);
    push_item(ACT_DATA, 8'h01);
    settle();

    write_config('1, '1, '1, '1);
    push_item(ACT_INIT, 8'hFF);
    push_item(ACT_DATA, 8'h00);
    push_item(ACT_DATA, 8'hFF);
    push_item(ACT_DATA, 8'h55);
    push_item(ACT_DATA, 8'hAA);
    push_item(ACT_INIT, 8'h3C);
    push_item(ACT_DATA, 8'h00);
    push_item(ACT_DATA, 8'h00);
    settle();

    write_config(64'h0123456789ABCDEF, 64'hFEDCBA9876543210, 64'hA5A5A5A5_DEADBEEF,
                 64'h0F1E2D3C4B5A6978);
    push_item(ACT_DATA, 8'h3C);
    push_item(ACT_INIT, 8'h00);
    push_item(ACT_DATA, 8'h00);
    push_item(ACT_DATA, 8'hFF);
    push_item(ACT_DATA, 8'h01);
    push_item(ACT_DATA, 8'h80);

    for (int ph = 0; ph < 8; ph++) begin
      settle();
      calm = (ph == 3 || ph == 6);
      if (ph == 2) write_config('0, '0, '0, '0);
      else if (ph == 5) write_config('1, '1, '1, '1);
      else write_config(rand64(), rand64(), rand64(), rand64());
      n = 0;
      while (n < PHASE_ITEMS) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          push_item(ACT_DATA, 8'($urandom_range(0, 255)));
          n++;
        end else if (pick == 1) begin
          push_item(ACT_INIT, 8'($urandom_range(0, 255)));
          n++;
        end else begin
          len = $urandom_range(1, 24);
          push_item(ACT_INIT, 8'($urandom_range(0, 255)));
          repeat (len) push_item(ACT_DATA, 8'($urandom_range(0, 255)));
          n += len + 1;
        end
      end
    end

    settle();
    repeat (50) @(negedge clk);
    if (due_outputs.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, due_outputs.size());
    end
    $display("Covered %0d initializations and %0d data bytes under %0d key/nonce settings,",
             n_init, n_data, n_settings);
    $display("including data before any init, repeated inits, all-zero/all-one keys, holds.");
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

[sim.f]
hdl/triad_pkg.sv
hdl/triad_ctrl.sv
hdl/triad_datapath.sv
hdl/triad_sc_keystream_cipher_top.sv
bench/tb.sv
